### rtl/assert_macros.svh
// Assertion macros for the RTL files.
// Each macro expects a clock named clk and an active-high reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every clock edge outside reset.
`define AST_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define AST_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define AST_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/macsm_pkg.sv
// ----------------------------------------------------------------------------
// macsm_pkg: shared types and helpers for the axis state machine
// Axis states, command codes, motion modes, register indexes and the
// position and transition helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package macsm_pkg;

  typedef enum logic [2:0] {
    ST_DISABLED   = 3'd0,
    ST_STANDSTILL = 3'd1,
    ST_HOMING     = 3'd2,
    ST_STOPPING   = 3'd3,
    ST_DISCRETE   = 3'd4,
    ST_CONTINUOUS = 3'd5,
    ST_ERRORSTOP  = 3'd6
  } axis_state_t;

  typedef enum logic [2:0] {
    OP_LOAD     = 3'd0,
    OP_START    = 3'd1,
    OP_ACTIVATE = 3'd2,
    OP_CHECK    = 3'd3,
    OP_COMPLETE = 3'd4,
    OP_ABORT    = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    MODE_NONE     = 3'd0,
    MODE_ABSOLUTE = 3'd1,
    MODE_RELATIVE = 3'd2,
    MODE_ADDITIVE = 3'd3,
    MODE_HALT     = 3'd4,
    MODE_STOP     = 3'd5,
    MODE_VELOCITY = 3'd6
  } motion_mode_t;

  typedef enum logic [1:0] {
    REG_MOTION_MODE     = 2'd0,
    REG_TARGET_POSITION = 2'd1,
    REG_TARGET_VELOCITY = 2'd2,
    REG_VEL_TOLERANCE   = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic error;
    logic aborted;
    logic active;
    logic busy;
    logic done;
  } status_t;

  // 0.015 in Q0.32, truncated.
  localparam logic [25:0] WINDOW_Q32 = 26'd64424509;

  localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] POS_MIN = 32'h8000_0000;

  // Magnitude of the difference of two signed 32-bit values.
  function automatic logic [31:0] abs_diff(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] d;
    logic [32:0] n;
    d = {a[31], a} - {b[31], b};
    n = -d;
    return d[32] ? n[31:0] : d[31:0];
  endfunction

  // True when the axis may move from cur to want.
  function automatic logic legal_move(input axis_state_t cur, input axis_state_t want);
    logic ok;
    case (cur)
      ST_STANDSTILL: ok = (want != ST_DISABLED);
      ST_HOMING:     ok = (want == ST_ERRORSTOP) || (want == ST_HOMING) ||
                          (want == ST_STOPPING) || (want == ST_STANDSTILL);
      ST_STOPPING:   ok = (want == ST_ERRORSTOP) || (want == ST_STOPPING) ||
                          (want == ST_STANDSTILL);
      ST_DISCRETE:   ok = (want == ST_ERRORSTOP) || (want == ST_STOPPING) ||
                          (want == ST_STANDSTILL) || (want == ST_DISCRETE) ||
                          (want == ST_CONTINUOUS);
      ST_CONTINUOUS: ok = (want == ST_ERRORSTOP) || (want == ST_STOPPING) ||
                          (want == ST_CONTINUOUS) || (want == ST_DISCRETE);
      default:       ok = 1'b0;
    endcase
    return ok;
  endfunction

endpackage

`default_nettype wire

### rtl/motion_command_axis_state_machine_unit.sv
// ----------------------------------------------------------------------------
// motion_command_axis_state_machine_unit
// Tracks one motion command against the axis state diagram: axis state,
// command status flags, error code, end targets and the done check.
// ----------------------------------------------------------------------------
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+--------------------------------------------------
//  command | in  | cmd_valid/cmd_stall | op, position/velocity_value, ref_position, ...
//  result  | out | res_valid/res_stall | axis_state, flags, fault_code, mission_done
//  config  | in  | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One command beat per cycle while the result channel is not stalled; each
// command waits in the input register, then the state update and
// the done check (one 32x26 multiply and compares) fill the result register.
// Reset is synchronous: it clears the axis state, flags and targets and sets
// the velocity tolerance to one. A stalled result holds the result register;
// the input register then holds too and cmd_stall rises while it is full.
// cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module motion_command_axis_state_machine_unit
  import macsm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // command channel
  input  wire logic        cmd_valid,
  output logic             cmd_stall,
  input  wire logic [2:0]  op,
  input  wire logic [31:0] position_value,
  input  wire logic [31:0] velocity_value,
  input  wire logic [31:0] ref_position,
  input  wire logic        axis_enabled,
  input  wire logic [2:0]  state_value,
  // result channel
  output logic             res_valid,
  input  wire logic        res_stall,
  output logic [2:0]       axis_state,
  output logic             done_res,
  output logic             busy_res,
  output logic             active,
  output logic             aborted,
  output logic             error_flag,
  output logic             fault_code,
  output logic             mission_done,
  // configuration channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  // configuration registers
  logic [2:0]  motion_mode;
  logic [31:0] target_position;
  logic [31:0] target_velocity;
  logic [15:0] vel_tolerance;

  // command state
  axis_state_t st, st_next;
  logic [31:0] start_position, start_position_next;
  logic [31:0] end_position, end_position_next;
  logic [31:0] end_velocity, end_velocity_next;
  logic [31:0] span, span_next;   // |start_position - end_position|
  status_t     flags, flags_next;
  logic        err, err_next;
  logic        mission;

  // input register
  logic        s_valid;
  logic [2:0]  s_op;
  logic [31:0] s_pos;
  logic [31:0] s_vel;
  logic [31:0] s_ref;
  logic        s_enabled;
  logic [2:0]  s_state_value;

  logic cmd_take;
  logic adv;
  logic s_fire;

  assign adv       = !res_valid || !res_stall;
  assign s_fire    = s_valid && adv;
  assign cmd_stall = s_valid && !adv;
  assign cmd_take  = cmd_valid && !cmd_stall;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      motion_mode     <= MODE_NONE;
      target_position <= '0;
      target_velocity <= '0;
      vel_tolerance   <= 16'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_MOTION_MODE:     motion_mode     <= cfg_data[2:0];
        REG_TARGET_POSITION: target_position <= cfg_data;
        REG_TARGET_VELOCITY: target_velocity <= cfg_data;
        REG_VEL_TOLERANCE:   vel_tolerance   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (cmd_take) begin
      s_valid <= 1'b1;
    end else if (s_fire) begin
      s_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      s_op          <= op;
      s_pos         <= position_value;
      s_vel         <= velocity_value;
      s_ref         <= ref_position;
      s_enabled     <= axis_enabled;
      s_state_value <= state_value;
    end
  end

  // End position for relative and additive starts, saturated, and the
  // matching span computed in parallel rather than from the saturated sum.
  logic [32:0] rel_sum;
  logic [32:0] add_sum;
  logic        rel_ovf;
  logic        add_ovf;
  logic [31:0] rel_end;
  logic [31:0] add_end;
  logic [33:0] add_d;
  logic [33:0] add_n;
  logic [31:0] add_raw;
  logic [31:0] rel_span;
  logic [31:0] add_span;

  assign rel_sum = {s_pos[31], s_pos} + {target_position[31], target_position};
  assign add_sum = {s_ref[31], s_ref} + {target_position[31], target_position};
  assign rel_ovf = rel_sum[32] ^ rel_sum[31];
  assign add_ovf = add_sum[32] ^ add_sum[31];
  assign rel_end = rel_ovf ? (rel_sum[32] ? POS_MIN : POS_MAX) : rel_sum[31:0];
  assign add_end = add_ovf ? (add_sum[32] ? POS_MIN : POS_MAX) : add_sum[31:0];

  assign add_d   = {{2{s_pos[31]}}, s_pos} - {{2{s_ref[31]}}, s_ref}
                 - {{2{target_position[31]}}, target_position};
  assign add_n   = -add_d;
  assign add_raw = add_d[33] ? add_n[31:0] : add_d[31:0];

  assign rel_span = rel_ovf ? abs_diff(s_pos, rel_end) : abs_diff(target_position, '0);
  assign add_span = add_ovf ? abs_diff(s_pos, add_end) : add_raw;

  // Done check: the position window is 0.015 of the commanded travel.
  logic [57:0] win_prod;
  logic [25:0] win;
  logic [31:0] pos_err;
  logic [31:0] vel_err;
  logic        pos_ok;
  logic        vel_ok;

  assign win_prod = {26'b0, span} * {32'b0, WINDOW_Q32};
  assign win      = win_prod[57:32];
  assign pos_err  = abs_diff(s_pos, end_position);
  assign vel_err  = abs_diff(s_vel, end_velocity);
  assign pos_ok   = pos_err < {6'b0, win};
  assign vel_ok   = vel_err < {16'b0, vel_tolerance};

  always_comb begin
    axis_state_t want;
    logic        req;
    st_next             = st;
    start_position_next = start_position;
    end_position_next   = end_position;
    end_velocity_next   = end_velocity;
    span_next           = span;
    flags_next          = flags;
    err_next            = err;
    mission             = 1'b0;
    want                = ST_DISABLED;
    req                 = 1'b0;
    case (s_op)
      OP_LOAD: begin
        if (s_state_value <= ST_ERRORSTOP) begin
          st_next = axis_state_t'(s_state_value);
        end
      end
      OP_START: begin
        start_position_next = s_pos;
        case (motion_mode)
          MODE_ABSOLUTE: begin
            end_position_next = target_position;
            end_velocity_next = '0;
            span_next         = abs_diff(s_pos, target_position);
          end
          MODE_RELATIVE: begin
            end_position_next = rel_end;
            end_velocity_next = '0;
            span_next         = rel_span;
          end
          MODE_ADDITIVE: begin
            end_position_next = add_end;
            end_velocity_next = '0;
            span_next         = add_span;
          end
          MODE_HALT, MODE_STOP: begin
            end_position_next = '0;
            end_velocity_next = '0;
            span_next         = abs_diff(s_pos, '0);
          end
          MODE_VELOCITY: begin
            end_position_next = '0;
            end_velocity_next = target_velocity;
            span_next         = abs_diff(s_pos, '0);
          end
          default: begin
            span_next = abs_diff(s_pos, end_position);
          end
        endcase
      end
      OP_ACTIVATE, OP_COMPLETE: begin
        case (motion_mode)
          MODE_ABSOLUTE, MODE_RELATIVE, MODE_ADDITIVE, MODE_HALT: begin
            req  = 1'b1;
            want = (s_op == OP_ACTIVATE) ? ST_DISCRETE : ST_STANDSTILL;
          end
          MODE_VELOCITY: begin
            req  = 1'b1;
            want = ST_CONTINUOUS;
          end
          MODE_STOP: begin
            req  = 1'b1;
            want = (s_op == OP_ACTIVATE || s_enabled) ? ST_STOPPING : ST_STANDSTILL;
          end
          default: begin
            req = 1'b0;
          end
        endcase
        if (req && !legal_move(st, want)) begin
          flags_next = '{error: 1'b1, default: 1'b0};
          err_next   = 1'b1;
        end else begin
          if (req) begin
            st_next = want;
          end
          if (s_op == OP_ACTIVATE) begin
            flags_next = '{busy: 1'b1, active: 1'b1, default: 1'b0};
          end else begin
            flags_next = '{done: 1'b1, default: 1'b0};
          end
        end
      end
      OP_CHECK: begin
        case (motion_mode)
          MODE_ABSOLUTE, MODE_RELATIVE, MODE_ADDITIVE: mission = pos_ok && vel_ok;
          MODE_HALT, MODE_STOP, MODE_VELOCITY:         mission = vel_ok;
          default:                                     mission = 1'b0;
        endcase
      end
      OP_ABORT: begin
        flags_next = '{aborted: 1'b1, default: 1'b0};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st             <= ST_DISABLED;
      start_position <= '0;
      end_position   <= '0;
      end_velocity   <= '0;
      span           <= '0;
      flags          <= '0;
      err            <= 1'b0;
    end else if (s_fire) begin
      st             <= st_next;
      start_position <= start_position_next;
      end_position   <= end_position_next;
      end_velocity   <= end_velocity_next;
      span           <= span_next;
      flags          <= flags_next;
      err            <= err_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      axis_state   <= st_next;
      done_res     <= flags_next.done;
      busy_res     <= flags_next.busy;
      active       <= flags_next.active;
      aborted      <= flags_next.aborted;
      error_flag   <= flags_next.error;
      fault_code   <= err_next;
      mission_done <= mission;
    end
  end

  // A reported error always carries the sticky violation code.
  `AST_IMPLY(a_err_code, res_valid && error_flag, fault_code, "error flag without fault code")
  // Busy and active are only ever set together.
  `AST_IMPLY(a_busy_active, res_valid, busy_res == active, "busy and active disagree")
  // The stored span always tracks the stored start and end positions.
  `AST_ALWAYS(a_span, span == abs_diff(start_position, end_position), "span out of step")
  // A command leaving the input register produces a result in the next cycle.
  `AST_NEXT(a_res_after_fire, s_fire, res_valid, "result missing after command")

endmodule

`default_nettype wire

### tb/tb_motion_command_axis_state_machine_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_motion_command_axis_state_machine_unit
// Drives command beats and register writes into the axis state machine and
// checks every result beat against an in-bench model of the axis states,
// status flags, end targets and done check. A short directed run comes
// first, then random command sequences under changing register settings,
// with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------

module tb_motion_command_axis_state_machine_unit;
  import macsm_pkg::*;

  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;
  localparam logic [2:0] MODE_SPARE  = 3'd7;
  localparam logic [2:0] ST_SPARE    = 3'd7;
  localparam int         MAX_SHOWN   = 10;

  typedef enum logic [1:0] {
    BL_COMMAND,
    BL_SETTING,
    BL_DRAIN
  } backlog_kind_t;

  typedef struct {
    backlog_kind_t kind;
    logic [2:0]    op;
    logic [31:0]   pos;
    logic [31:0]   vel;
    logic [31:0]   refp;
    logic          en;
    logic [2:0]    sv;
    int            gap;
    cfg_reg_t      idx;
    logic [31:0]   val;
  } backlog_t;

  typedef struct packed {
    logic [2:0] st;
    logic       done;
    logic       busy;
    logic       act;
    logic       abrt;
    logic       err;
    logic       code;
    logic       hit;
  } axis_report_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        cmd_valid = 1'b0;
  logic        cmd_stall;
  logic [2:0]  op = '0;
  logic [31:0] position_value = '0;
  logic [31:0] velocity_value = '0;
  logic [31:0] ref_position = '0;
  logic        axis_enabled = 1'b0;
  logic [2:0]  state_value = '0;
  logic        res_valid;
  logic        res_stall;
  logic [2:0]  axis_state;
  logic        done_res;
  logic        busy_res;
  logic        active;
  logic        aborted;
  logic        error_flag;
  logic        fault_code;
  logic        mission_done;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  logic        hold_long = 1'b0;
  logic        gap_stall = 1'b0;
  assign res_stall = hold_long | gap_stall;

  motion_command_axis_state_machine_unit u_dut (
    .clk            (clk),
    .rst            (rst),
    .cmd_valid      (cmd_valid),
    .cmd_stall      (cmd_stall),
    .op             (op),
    .position_value (position_value),
    .velocity_value (velocity_value),
    .ref_position   (ref_position),
    .axis_enabled   (axis_enabled),
    .state_value    (state_value),
    .res_valid      (res_valid),
    .res_stall      (res_stall),
    .axis_state     (axis_state),
    .done_res       (done_res),
    .busy_res       (busy_res),
    .active         (active),
    .aborted        (aborted),
    .error_flag     (error_flag),
    .fault_code     (fault_code),
    .mission_done   (mission_done),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Model state, updated only by the driver at accepted beats.
  logic [2:0]  mode_r = MODE_NONE;
  logic [31:0] tpos_r = '0;
  logic [31:0] tvel_r = '0;
  logic [15:0] tol_r = 16'd1;
  axis_state_t ax_state = ST_DISABLED;
  logic [31:0] org_pos = '0;
  logic [31:0] goal_pos = '0;
  logic [31:0] goal_vel = '0;
  status_t     flags = '0;
  logic        err_r = 1'b0;

  backlog_t     cmd_backlog[$];
  axis_report_t reports_due[$];
  int           n_sent = 0;
  int           n_done = 0;
  int           n_errors = 0;
  int           n_items = 0;

  // Generator's view of the registers, used to aim checks near the targets.
  logic [2:0]  g_mode = MODE_NONE;
  logic [31:0] g_tpos = '0;
  logic [31:0] g_tvel = '0;
  logic [15:0] g_tol = 16'd1;
  bit          g_calm = 1'b1;

  function automatic longint unsigned span(input logic [31:0] a, input logic [31:0] b);
    longint d;
    d = longint'($signed(a)) - longint'($signed(b));
    return (d < 0) ? -d : d;
  endfunction

  function automatic logic [31:0] clamp_sum(input logic [31:0] a, input logic [31:0] b);
    longint s;
    s = longint'($signed(a)) + longint'($signed(b));
    if (s > longint'($signed(POS_MAX))) return POS_MAX;
    if (s < longint'($signed(POS_MIN))) return POS_MIN;
    return s[31:0];
  endfunction

  // Bit w is set when the axis may move from cur to state w.
  function automatic logic [6:0] reachable_from(input axis_state_t cur);
    case (cur)
      ST_STANDSTILL: return 7'b111_1110;
      ST_HOMING:     return 7'b100_1110;
      ST_STOPPING:   return 7'b100_1010;
      ST_DISCRETE:   return 7'b111_1010;
      ST_CONTINUOUS: return 7'b111_1000;
      default:       return 7'b000_0000;
    endcase
  endfunction

  function automatic void request_move(input logic wanted, input axis_state_t goal,
                                       input logic completing);
    logic [6:0] legal;
    legal = reachable_from(ax_state);
    flags = '0;
    if (wanted && !legal[goal]) begin
      flags.error = 1'b1;
      err_r = 1'b1;
    end else begin
      if (wanted) ax_state = goal;
      if (completing) begin
        flags.done = 1'b1;
      end else begin
        flags.busy = 1'b1;
        flags.active = 1'b1;
      end
    end
  endfunction

  function automatic logic done_check(input logic [31:0] p, input logic [31:0] v);
    logic            vel_ok;
    longint unsigned win;
    vel_ok = span(v, goal_vel) < {48'd0, tol_r};
    case (mode_r)
      MODE_ABSOLUTE, MODE_RELATIVE, MODE_ADDITIVE: begin
        win = (span(org_pos, goal_pos) * {38'd0, WINDOW_Q32}) >> 32;
        return (span(p, goal_pos) < win) && vel_ok;
      end
      MODE_HALT, MODE_STOP, MODE_VELOCITY: return vel_ok;
      default: return 1'b0;
    endcase
  endfunction

  function automatic axis_report_t advance_axis(input backlog_t c);
    axis_report_t r;
    logic         hit;
    hit = 1'b0;
    case (c.op)
      OP_LOAD: if (c.sv != ST_SPARE) ax_state = axis_state_t'(c.sv);
      OP_START: begin
        org_pos = c.pos;
        case (mode_r)
          MODE_ABSOLUTE: begin goal_pos = tpos_r; goal_vel = '0; end
          MODE_RELATIVE: begin goal_pos = clamp_sum(c.pos, tpos_r); goal_vel = '0; end
          MODE_ADDITIVE: begin goal_pos = clamp_sum(c.refp, tpos_r); goal_vel = '0; end
          MODE_HALT, MODE_STOP: begin goal_pos = '0; goal_vel = '0; end
          MODE_VELOCITY: begin goal_pos = '0; goal_vel = tvel_r; end
          default: ;
        endcase
      end
      OP_ACTIVATE: begin
        case (mode_r)
          MODE_ABSOLUTE, MODE_RELATIVE, MODE_ADDITIVE, MODE_HALT:
            request_move(1'b1, ST_DISCRETE, 1'b0);
          MODE_VELOCITY: request_move(1'b1, ST_CONTINUOUS, 1'b0);
          MODE_STOP:     request_move(1'b1, ST_STOPPING, 1'b0);
          default:       request_move(1'b0, ST_DISABLED, 1'b0);
        endcase
      end
      OP_CHECK: hit = done_check(c.pos, c.vel);
      OP_COMPLETE: begin
        case (mode_r)
          MODE_ABSOLUTE, MODE_RELATIVE, MODE_ADDITIVE, MODE_HALT:
            request_move(1'b1, ST_STANDSTILL, 1'b1);
          MODE_VELOCITY: request_move(1'b1, ST_CONTINUOUS, 1'b1);
          MODE_STOP:     request_move(1'b1, c.en ? ST_STOPPING : ST_STANDSTILL, 1'b1);
          default:       request_move(1'b0, ST_DISABLED, 1'b1);
        endcase
      end
      OP_ABORT: begin
        flags = '0;
        flags.aborted = 1'b1;
      end
      default: ;
    endcase
    r.st   = ax_state;
    r.done = flags.done;
    r.busy = flags.busy;
    r.act  = flags.active;
    r.abrt = flags.aborted;
    r.err  = flags.error;
    r.code = err_r;
    r.hit  = hit;
    return r;
  endfunction

  function automatic void apply_setting(input cfg_reg_t idx, input logic [31:0] val);
    case (idx)
      REG_MOTION_MODE:     mode_r = val[2:0];
      REG_TARGET_POSITION: tpos_r = val;
      REG_TARGET_VELOCITY: tvel_r = val;
      REG_VEL_TOLERANCE:   tol_r = val[15:0];
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic logic pick_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic logic [2:0] pick_code();
    return 3'($urandom_range(0, 7));
  endfunction

  function automatic void queue_cmd(input logic [2:0] o, input logic [31:0] p,
                                    input logic [31:0] v, input logic [31:0] rp,
                                    input logic e, input logic [2:0] s);
    backlog_t b;
    b.kind = BL_COMMAND;
    b.op = o;
    b.pos = p;
    b.vel = v;
    b.refp = rp;
    b.en = e;
    b.sv = s;
    b.gap = g_calm ? 0 : int'($urandom_range(0, 12));
    b.idx = REG_MOTION_MODE;
    b.val = '0;
    cmd_backlog.push_back(b);
    if (o != OP_SPARE_LO && o != OP_SPARE_HI) n_items++;
  endfunction

  function automatic void queue_setting(input cfg_reg_t idx, input logic [31:0] val);
    backlog_t b;
    b = '{kind: BL_SETTING, op: '0, pos: '0, vel: '0, refp: '0, en: 1'b0, sv: '0,
          gap: 0, idx: idx, val: val};
    cmd_backlog.push_back(b);
    case (idx)
      REG_MOTION_MODE:     g_mode = val[2:0];
      REG_TARGET_POSITION: g_tpos = val;
      REG_TARGET_VELOCITY: g_tvel = val;
      default:             g_tol = val[15:0];
    endcase
  endfunction

  function automatic void queue_drain();
    backlog_t b;
    b = '{kind: BL_DRAIN, op: '0, pos: '0, vel: '0, refp: '0, en: 1'b0, sv: '0,
          gap: 0, idx: REG_MOTION_MODE, val: '0};
    cmd_backlog.push_back(b);
  endfunction

  function automatic logic [31:0] pick_position();
    case ($urandom_range(0, 5))
      0:       return POS_MAX;
      1:       return POS_MIN;
      2:       return '0;
      3:       return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] pick_tolerance();
    case ($urandom_range(0, 5))
      0:       return 16'd0;
      1:       return 16'd1;
      2:       return 16'hFFFF;
      3:       return 16'($urandom_range(0, 255));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // A value within +/- reach of base, wrapping at the 32-bit range.
  function automatic logic [31:0] nudge(input logic [31:0] base, input longint unsigned reach);
    longint off;
    off = $urandom_range(0, 32'(2 * reach));
    off = off - longint'(reach);
    return base + off[31:0];
  endfunction

  function automatic void queue_noise();
    queue_cmd(pick_code(), $urandom, $urandom, $urandom, pick_bit(), pick_code());
  endfunction

  // Load a start state, start, often activate, up to three checks near the targets, complete.
  function automatic void queue_sequence();
    logic [31:0]     s;
    logic [31:0]     rp;
    logic [31:0]     e;
    logic [31:0]     ev;
    longint unsigned reach;
    longint unsigned vreach;
    axis_state_t     st0;
    case ($urandom_range(0, 9))
      6:       st0 = ST_HOMING;
      7:       st0 = ST_DISCRETE;
      8:       st0 = ST_CONTINUOUS;
      9:       st0 = ST_STOPPING;
      default: st0 = ST_STANDSTILL;
    endcase
    queue_cmd(OP_LOAD, $urandom, $urandom, $urandom, pick_bit(), st0);
    s = pick_position();
    rp = pick_position();
    case (g_mode)
      MODE_ABSOLUTE: e = g_tpos;
      MODE_RELATIVE: e = clamp_sum(s, g_tpos);
      MODE_ADDITIVE: e = clamp_sum(rp, g_tpos);
      default:       e = s;
    endcase
    ev = (g_mode == MODE_VELOCITY) ? g_tvel : '0;
    reach = span(s, e) >> 5;
    vreach = 2 * longint'(g_tol) + 1;
    queue_cmd(OP_START, s, $urandom, rp, pick_bit(), pick_code());
    if ($urandom_range(0, 7) != 0)
      queue_cmd(OP_ACTIVATE, $urandom, $urandom, $urandom, pick_bit(), pick_code());
    repeat ($urandom_range(0, 3))
      queue_cmd(OP_CHECK, nudge(e, reach), nudge(ev, vreach), $urandom,
                pick_bit(), pick_code());
    if ($urandom_range(0, 5) == 0)
      queue_cmd(OP_ABORT, $urandom, $urandom, $urandom, pick_bit(), pick_code());
    queue_cmd(OP_COMPLETE, $urandom, $urandom, $urandom, pick_bit(), pick_code());
    if ($urandom_range(0, 3) == 0)
      queue_cmd(OP_CHECK, nudge(e, reach), nudge(ev, vreach), $urandom,
                pick_bit(), pick_code());
  endfunction

  initial begin : stimulus
    int          phase;
    logic [31:0] word;
    // Reset settings: mode none, so requests succeed without moving the axis.
    queue_cmd(OP_SPARE_LO, '0, '0, '0, 1'b0, ST_DISABLED);
    queue_cmd(OP_SPARE_HI, POS_MAX, POS_MAX, POS_MAX, 1'b1, ST_SPARE);
    queue_cmd(OP_LOAD, '0, '0, '0, 1'b0, ST_SPARE);
    queue_cmd(OP_ACTIVATE, '0, '0, '0, 1'b0, ST_DISABLED);
    queue_cmd(OP_COMPLETE, '0, '0, '0, 1'b1, ST_DISABLED);
    queue_cmd(OP_START, POS_MAX, '0, POS_MIN, 1'b0, ST_DISABLED);
    queue_cmd(OP_CHECK, '0, '0, '0, 1'b0, ST_DISABLED);
    queue_setting(REG_MOTION_MODE, {29'd0, MODE_RELATIVE});
    queue_setting(REG_TARGET_POSITION, POS_MAX);
    queue_setting(REG_TARGET_VELOCITY, POS_MIN);
    queue_setting(REG_VEL_TOLERANCE, 32'hFFFF_FFFF);
    queue_cmd(OP_ACTIVATE, '0, '0, '0, 1'b0, ST_DISABLED);
    queue_cmd(OP_LOAD, '0, '0, '0, 1'b0, ST_STANDSTILL);
    // Relative sum overflows high; zero distance leaves an empty window.
    queue_cmd(OP_START, POS_MAX, '0, '0, 1'b0, ST_DISABLED);
    queue_cmd(OP_CHECK, POS_MAX, '0, '0, 1'b0, ST_DISABLED);
    queue_cmd(OP_ACTIVATE, '0, '0, '0, 1'b0, ST_DISABLED);
    queue_cmd(OP_COMPLETE, '0, '0, '0, 1'b0, ST_DISABLED);
    queue_setting(REG_MOTION_MODE, {29'h1555_5555, MODE_ADDITIVE});
    queue_setting(REG_TARGET_POSITION, POS_MIN);
    // Additive sum overflows low; the check lands inside the full-range window.
    queue_cmd(OP_START, POS_MAX, '0, POS_MIN, 1'b0, ST_DISABLED);
    queue_cmd(OP_CHECK, POS_MIN + 32'd1000, 32'h0000_7FFF, '0, 1'b0, ST_DISABLED);
    queue_setting(REG_MOTION_MODE, {29'd0, MODE_STOP});
    queue_cmd(OP_ACTIVATE, '0, '0, '0, 1'b0, ST_DISABLED);
    queue_cmd(OP_COMPLETE, '0, '0, '0, 1'b1, ST_DISABLED);
    queue_cmd(OP_COMPLETE, '0, '0, '0, 1'b0, ST_DISABLED);
    queue_setting(REG_MOTION_MODE, {29'd0, MODE_VELOCITY});
    queue_cmd(OP_START, '0, '0, '0, 1'b0, ST_DISABLED);
    queue_cmd(OP_ACTIVATE, '0, '0, '0, 1'b0, ST_DISABLED);
    queue_cmd(OP_CHECK, '0, POS_MIN + 32'd5, '0, 1'b0, ST_DISABLED);
    queue_cmd(OP_ABORT, '0, '0, '0, 1'b0, ST_DISABLED);
    queue_cmd(OP_LOAD, '0, '0, '0, 1'b0, ST_ERRORSTOP);
    queue_cmd(OP_COMPLETE, '0, '0, '0, 1'b0, ST_DISABLED);
    queue_setting(REG_MOTION_MODE, {29'h1FFF_FFFF, MODE_SPARE});
    queue_cmd(OP_START, 32'h0001_0000, '0, '0, 1'b0, ST_DISABLED);
    queue_cmd(OP_ACTIVATE, '0, '0, '0, 1'b0, ST_DISABLED);
    queue_cmd(OP_CHECK, '0, '0, '0, 1'b0, ST_DISABLED);

    phase = 0;
    while (n_items < 1325) begin
      g_calm = ($urandom_range(0, 4) == 0);
      queue_drain();
      word = ($urandom_range(0, 1) != 0) ? $urandom : '0;
      word[2:0] = ($urandom_range(0, 3) == 0) ? pick_code() : 3'(phase % 8);
      queue_setting(REG_MOTION_MODE, word);
      if (phase == 0 || $urandom_range(0, 1) != 0)
        queue_setting(REG_TARGET_POSITION, pick_position());
      if (phase == 0 || $urandom_range(0, 1) != 0)
        queue_setting(REG_TARGET_VELOCITY, pick_position());
      if (phase == 0 || $urandom_range(0, 1) != 0) begin
        word = ($urandom_range(0, 1) != 0) ? $urandom : '0;
        word[15:0] = pick_tolerance();
        queue_setting(REG_VEL_TOLERANCE, word);
      end
      repeat ($urandom_range(5, 10)) begin
        if ($urandom_range(0, 4) == 0) begin
          repeat ($urandom_range(1, 3)) queue_noise();
        end else begin
          queue_sequence();
        end
        if ($urandom_range(0, 11) == 0) queue_drain();
      end
      phase++;
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    do @(posedge clk);
    while (cmd_backlog.size() != 0 || cmd_valid || cfg_valid || n_sent != n_done);
    repeat (10) @(posedge clk);
    if (n_errors == 0 && reports_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // ------------------------------------------------------------------ driver

  backlog_t cur_cmd;
  bit       armed = 1'b0;
  int       wait_left = 0;

  always @(posedge clk) begin : drive_beats
    logic     v_next;
    logic     c_next;
    backlog_t hd;
    if (rst) begin
      cmd_valid <= 1'b0;
      cfg_valid <= 1'b0;
      armed = 1'b0;
      wait_left = 0;
      mode_r = MODE_NONE;
      tpos_r = '0;
      tvel_r = '0;
      tol_r = 16'd1;
      ax_state = ST_DISABLED;
      org_pos = '0;
      goal_pos = '0;
      goal_vel = '0;
      flags = '0;
      err_r = 1'b0;
    end else begin
      v_next = cmd_valid;
      c_next = cfg_valid;
      if (cmd_valid && !cmd_stall) begin
        reports_due.push_back(advance_axis(cur_cmd));
        n_sent++;
        v_next = 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        apply_setting(cfg_reg_t'(cfg_index), cfg_data);
        c_next = 1'b0;
      end
      if (!v_next && !c_next && cmd_backlog.size() != 0) begin
        hd = cmd_backlog[0];
        if (!armed) begin
          wait_left = (hd.kind == BL_COMMAND) ? hd.gap : 0;
          armed = 1'b1;
        end
        if (wait_left > 0) begin
          wait_left--;
        end else begin
          case (hd.kind)
            BL_COMMAND: begin
              op <= hd.op;
              position_value <= hd.pos;
              velocity_value <= hd.vel;
              ref_position <= hd.refp;
              axis_enabled <= hd.en;
              state_value <= hd.sv;
              cur_cmd = hd;
              v_next = 1'b1;
              void'(cmd_backlog.pop_front());
              armed = 1'b0;
            end
            // Registers change only once every result beat has come back.
            BL_SETTING: if (n_sent == n_done) begin
              cfg_index <= hd.idx;
              cfg_data <= hd.val;
              c_next = 1'b1;
              void'(cmd_backlog.pop_front());
              armed = 1'b0;
            end
            default: if (n_sent == n_done) begin
              void'(cmd_backlog.pop_front());
              armed = 1'b0;
            end
          endcase
        end
      end
      cmd_valid <= v_next;
      cfg_valid <= c_next;
    end
  end

  // ----------------------------------------------------------------- monitor

  int stall_left = 0;
  bit rx_calm = 1'b0;

  always @(posedge clk) begin : check_results
    axis_report_t got;
    axis_report_t want;
    if (rst) begin
      gap_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (res_valid && !res_stall) begin
        got = {axis_state, done_res, busy_res, active, aborted, error_flag,
               fault_code, mission_done};
        if (reports_due.size() == 0) begin
          n_errors++;
          if (n_errors <= MAX_SHOWN)
            $display("unexpected result beat: state=%0d flags=%b%b%b%b%b code=%b mission=%b",
                     got.st, got.done, got.busy, got.act, got.abrt, got.err, got.code,
                     got.hit);
        end else begin
          want = reports_due.pop_front();
          n_done <= n_done + 1;
          if (got.st !== want.st || got.done !== want.done || got.busy !== want.busy ||
              got.act !== want.act || got.abrt !== want.abrt || got.err !== want.err ||
              got.code !== want.code || got.hit !== want.hit) begin
            n_errors++;
            if (n_errors <= MAX_SHOWN) begin
              $display("result %0d mismatch (state done busy active aborted error code mission)",
                       n_done);
              $display("  expected %0d %b %b %b %b %b %b %b", want.st, want.done, want.busy,
                       want.act, want.abrt, want.err, want.code, want.hit);
              $display("  actual   %0d %b %b %b %b %b %b %b", got.st, got.done, got.busy,
                       got.act, got.abrt, got.err, got.code, got.hit);
            end
          end
        end
        if (n_done % 64 == 0) rx_calm = ($urandom_range(0, 3) == 0);
        stall_left = rx_calm ? 0 : int'($urandom_range(0, 12));
      end else if (stall_left > 0) begin
        stall_left--;
      end
      gap_stall <= (stall_left > 0);
    end
  end

  // One long receiver hold-off while the sender keeps offering, to fill the
  // pipeline and push back on the command channel.
  initial begin : long_hold
    do @(posedge clk);
    while (n_done < 500 || !cmd_valid);
    hold_long <= 1'b1;
    repeat (300) @(posedge clk);
    hold_long <= 1'b0;
  end

  initial begin : watchdog
    #4_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/macsm_pkg.sv
rtl/motion_command_axis_state_machine_unit.sv
tb/tb_motion_command_axis_state_machine_unit.sv
